FILE: rtl/core/keyed_count_table_macros.svh
// Assertion macros for the keyed count table design.
`ifndef KEYED_COUNT_TABLE_MACROS_SVH
`define KEYED_COUNT_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside of reset.
`define KCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked on every rising clock edge, reset included.
`define KCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KCT_ASSERT(lbl, prop, msg)
`define KCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/kct_pkg.sv
// Types and constants for the keyed count table.
package kct_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EXEC
  } state_t;

  // Request codes.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_IGNORED  = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // Count field.
  localparam int          COUNT_BITS = 31;
  localparam logic [30:0] COUNT_MAX  = 31'h7FFF_FFFF;

  // Reset value of the entry limit register.
  localparam logic [4:0] MAX_ENTRIES_RESET = 5'd16;

endpackage

FILE: rtl/core/kct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/keyed_count_table.sv
// A request word is taken only while idle. It then passes the key scan, which reads one
// table entry per cycle through the single RAM read port, a drain state, and execution,
// which registers the result word once the output is free; only then is the next taken.
// A clear request skips the scan and goes straight to execution.
// Reset (rst, synchronous): table empty, entry limit 16, no result pending;
// the RAM contents are not cleared and are only read behind a set valid bit.
`include "keyed_count_table_macros.svh"

module keyed_count_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration: max_entries.
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] item_key, [63:32] amount, [64] key_flag, [96:65] min_count, [103:97] zero
  input  logic [103:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]   s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [30:0] count_out, [31] has_enough, [32] changed, [39:33] zero
  output logic [39:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]   m_axis_tuser
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OCC_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_W = KEY_BITS + kct_pkg::COUNT_BITS + 1;

  kct_pkg::state_t state, state_next;

  // Configuration register.
  logic [4:0] max_entries;

  // Captured request.
  logic [1:0]          req_q;
  logic [KEY_BITS-1:0] key_q;
  logic signed [31:0]  amt_q;
  logic                flag_q;
  logic signed [31:0]  minc_q;

  // Scan state.
  logic [IDX_W-1:0] scan_idx;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_valid_bit;
  logic             found;
  logic [IDX_W-1:0] match_idx;
  logic [30:0]      match_cnt;
  logic             match_flag;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // Table occupancy.
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [OCC_W-1:0]       occ;

  // RAM ports.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // EXEC decisions.
  logic        exec_fire;
  logic        set_valid;
  logic        clr_valid;
  logic        clr_all;
  logic [1:0]  res_status;
  logic [30:0] res_count;
  logic        res_enough;
  logic        res_changed;

  // Shared adder.
  logic               alu_sub;
  logic signed [33:0] alu_a;
  logic signed [33:0] alu_b;
  logic signed [33:0] alu_res;

  logic accept;
  logic out_free;
  logic table_full;
  logic amt_nonpos;
  logic key_zero;
  logic rd_match;
  logic [KEY_BITS-1:0] rd_key;

  kct_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = (state == kct_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= kct_pkg::MAX_ENTRIES_RESET;
    end else if (cfg_we) begin
      max_entries <= cfg_wdata;
    end
  end

  // Request capture; the key keeps only its low KEY_BITS bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= s_axis_tuser;
      key_q  <= KEY_BITS'(s_axis_tdata[31:0]);
      amt_q  <= s_axis_tdata[63:32];
      flag_q <= s_axis_tdata[64];
      minc_q <= s_axis_tdata[96:65];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      kct_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (s_axis_tuser == kct_pkg::REQ_CLEAR) ? kct_pkg::ST_EXEC
                                                             : kct_pkg::ST_SCAN;
        end
      end
      kct_pkg::ST_SCAN: begin
        if (scan_idx == IDX_W'(TABLE_DEPTH - 1)) begin
          state_next = kct_pkg::ST_DRAIN;
        end
      end
      kct_pkg::ST_DRAIN: state_next = kct_pkg::ST_EXEC;
      kct_pkg::ST_EXEC: begin
        if (out_free) begin
          state_next = kct_pkg::ST_IDLE;
        end
      end
      default: state_next = kct_pkg::ST_IDLE;
    endcase
  end

  // Scan address and the compare stage behind the RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= (state == kct_pkg::ST_SCAN);
    end
    if (accept) begin
      scan_idx <= '0;
    end else if (state == kct_pkg::ST_SCAN && scan_idx != IDX_W'(TABLE_DEPTH - 1)) begin
      scan_idx <= scan_idx + 1'b1;
    end
    chk_idx       <= scan_idx;
    chk_valid_bit <= entry_valid[scan_idx];
  end

  assign rd_key   = ram_rdata[KEY_BITS-1:0];
  assign rd_match = chk_vld && chk_valid_bit && (rd_key == key_q);

  // Keep the first matching entry and the lowest free entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (chk_vld) begin
      if (rd_match && !found) begin
        found <= 1'b1;
      end
      if (!chk_valid_bit && !free_found) begin
        free_found <= 1'b1;
      end
    end
    if (rd_match && !found) begin
      match_idx  <= chk_idx;
      match_cnt  <= ram_rdata[KEY_BITS +: kct_pkg::COUNT_BITS];
      match_flag <= ram_rdata[WORD_W-1];
    end
    if (chk_vld && !chk_valid_bit && !free_found) begin
      free_idx <= chk_idx;
    end
  end

  // Shared adder: add amount, subtract amount, or subtract the threshold.
  assign alu_sub = (req_q != kct_pkg::REQ_ADD);
  assign alu_a   = found ? $signed({3'b000, match_cnt}) : '0;
  assign alu_b   = (req_q == kct_pkg::REQ_QUERY) ? 34'(minc_q) : 34'(amt_q);
  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  assign key_zero   = (key_q == '0);
  assign amt_nonpos = amt_q[31] || (amt_q == '0);
  assign table_full = (occ == OCC_W'(TABLE_DEPTH)) || (32'(occ) >= 32'(max_entries));

  // Request execution and write-back decision.
  always_comb begin
    exec_fire   = (state == kct_pkg::ST_EXEC) && out_free;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    clr_all     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = match_idx;
    ram_wdata   = {match_flag | flag_q, alu_res[30:0], key_q};
    res_status  = kct_pkg::STAT_DONE;
    res_count   = '0;
    res_enough  = 1'b0;
    res_changed = 1'b0;
    case (req_q)
      kct_pkg::REQ_ADD: begin
        if (key_zero || amt_nonpos) begin
          res_status = kct_pkg::STAT_IGNORED;
        end else if (found) begin
          res_count   = alu_res[31] ? kct_pkg::COUNT_MAX : alu_res[30:0];
          ram_wdata   = {match_flag | flag_q, res_count, key_q};
          ram_we      = exec_fire;
          res_changed = 1'b1;
        end else if (table_full) begin
          res_status = kct_pkg::STAT_FULL;
        end else begin
          res_count   = amt_q[30:0];
          ram_waddr   = free_idx;
          ram_wdata   = {flag_q, amt_q[30:0], key_q};
          ram_we      = exec_fire;
          set_valid   = exec_fire;
          res_changed = 1'b1;
        end
      end
      kct_pkg::REQ_REMOVE: begin
        if (key_zero) begin
          res_status = kct_pkg::STAT_IGNORED;
        end else if (amt_nonpos) begin
          res_status = kct_pkg::STAT_IGNORED;
          res_count  = found ? match_cnt : '0;
        end else if (!found) begin
          res_status = kct_pkg::STAT_NOTFOUND;
        end else if (alu_res[33] || alu_res == '0) begin
          clr_valid   = exec_fire;
          res_changed = 1'b1;
        end else begin
          res_count   = alu_res[30:0];
          ram_wdata   = {match_flag, alu_res[30:0], key_q};
          ram_we      = exec_fire;
          res_changed = 1'b1;
        end
      end
      kct_pkg::REQ_QUERY: begin
        if (key_zero) begin
          res_status = kct_pkg::STAT_IGNORED;
        end else if (!found) begin
          res_status = kct_pkg::STAT_NOTFOUND;
        end else begin
          res_count = match_cnt;
        end
        res_enough = !alu_res[33];
      end
      kct_pkg::REQ_CLEAR: begin
        clr_all     = exec_fire;
        res_changed = 1'b1;
      end
      default: res_status = kct_pkg::STAT_IGNORED;
    endcase
  end

  // Valid bits and occupancy count.
  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      entry_valid <= '0;
      occ         <= '0;
    end else if (set_valid) begin
      entry_valid[free_idx] <= 1'b1;
      occ                   <= occ + 1'b1;
    end else if (clr_valid) begin
      entry_valid[match_idx] <= 1'b0;
      occ                    <= occ - 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (exec_fire) begin
      m_axis_tdata <= {7'b0, res_changed, res_enough, res_count};
      m_axis_tuser <= res_status;
    end
  end

  // Checks.
  `KCT_ASSERT(a_occ_matches_valid, occ == OCC_W'($countones(entry_valid)), "occupancy count differs from valid bits")
  `KCT_ASSERT(a_occ_bounded, 32'(occ) <= 32'(TABLE_DEPTH), "occupancy above table depth")
  `KCT_ASSERT(a_match_is_valid, (state == kct_pkg::ST_EXEC && found) |-> entry_valid[match_idx], "matched entry is not valid at execution")
  `KCT_ASSERT(a_result_from_exec, $rose(m_axis_tvalid) |-> $past(state == kct_pkg::ST_EXEC), "result word raised outside execution")
  `KCT_ASSERT(a_no_compare_in_exec, (state == kct_pkg::ST_EXEC) |-> !chk_vld, "compare stage busy during execution")

endmodule

FILE: sim/keyed_count_table_tb.sv
// Self-checking testbench for the keyed count table: directed and random requests.
module keyed_count_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int KEY_POOL     = 24;
  localparam int SEGMENTS     = 7;
  localparam int SEG_ITEMS    = 200;
  localparam int MAX_GAP      = 12;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = DEPTH + 8;
  localparam int CYCLE_LIMIT  = 500_000;

  // One request word as the stimulus sees it, with its lead-in gap.
  typedef struct {
    logic [1:0]         req;
    logic [31:0]        key;
    logic signed [31:0] amount;
    logic               flag;
    logic signed [31:0] min_cnt;
    int                 gap;
  } request_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] count;
    logic        enough;
    logic        changed;
  } reply_t;

  logic         clk           = 1'b0;
  logic         rst           = 1'b1;
  logic         cfg_we        = 1'b0;
  logic [4:0]   cfg_wdata     = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [31:0] item_key, [63:32] amount, [64] key_flag, [96:65] min_count, [103:97] zero
  logic [103:0] s_axis_tdata  = '0;
  // [1:0] req_type
  logic [1:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  // [30:0] count_out, [31] has_enough, [32] changed, [39:33] zero
  logic [39:0]  m_axis_tdata;
  // [1:0] status
  logic [1:0]   m_axis_tuser;

  keyed_count_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the table and its entry limit.
  logic [31:0] tbl_key   [DEPTH];
  logic [30:0] tbl_count [DEPTH];
  logic        tbl_flag  [DEPTH];
  logic        tbl_used  [DEPTH];
  logic [4:0]  key_limit;

  request_t    request_fifo[$];
  reply_t      count_replies_due[$];
  logic [31:0] key_pool[KEY_POOL];

  request_t    bus_req;
  logic        req_taken     = 1'b0;
  logic        rsp_taken     = 1'b0;
  logic        src_loaded    = 1'b0;
  logic        src_busy      = 1'b0;
  int          src_wait      = 0;
  int          snk_wait      = 0;
  int          src_max_gap   = MAX_GAP;
  int          snk_max_stall = MAX_GAP;
  int          fail_count    = 0;
  int          cycle_count   = 0;

  // Applies one request to the shadow table and returns the result it must give.
  function automatic reply_t table_apply(request_t r);
    reply_t rep;
    int     hit;
    int     free_slot;
    int     held;
    int     limit;
    longint total;
    rep       = '0;
    hit       = -1;
    free_slot = -1;
    held      = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_used[i] && tbl_key[i] == r.key && hit < 0) hit = i;
      if (tbl_used[i]) held++;
      else if (free_slot < 0) free_slot = i;
    end
    case (r.req)
      kct_pkg::REQ_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) tbl_used[i] = 1'b0;
        rep.changed = 1'b1;
      end
      kct_pkg::REQ_QUERY: begin
        if (r.key == '0) rep.status = kct_pkg::STAT_IGNORED;
        else if (hit < 0) rep.status = kct_pkg::STAT_NOTFOUND;
        else rep.count = tbl_count[hit];
        rep.enough = (longint'(rep.count) >= longint'(r.min_cnt)) ? 1'b1 : 1'b0;
      end
      kct_pkg::REQ_ADD: begin
        if (r.key == '0 || r.amount <= 0) begin
          rep.status = kct_pkg::STAT_IGNORED;
        end else if (hit >= 0) begin
          // Existing key: saturating add, sticky flag.
          total = longint'(tbl_count[hit]) + longint'(r.amount);
          tbl_count[hit] = (total > longint'(kct_pkg::COUNT_MAX)) ? kct_pkg::COUNT_MAX
                                                                 : total[30:0];
          tbl_flag[hit]  = tbl_flag[hit] | r.flag;
          rep.count      = tbl_count[hit];
          rep.changed    = 1'b1;
        end else begin
          // New key: lowest free slot, within the entry limit.
          limit = (key_limit > DEPTH) ? DEPTH : int'(key_limit);
          if (held >= limit || free_slot < 0) begin
            rep.status = kct_pkg::STAT_FULL;
          end else begin
            tbl_used[free_slot]  = 1'b1;
            tbl_key[free_slot]   = r.key;
            tbl_count[free_slot] = r.amount[30:0];
            tbl_flag[free_slot]  = r.flag;
            rep.count            = r.amount[30:0];
            rep.changed          = 1'b1;
          end
        end
      end
      default: begin
        if (r.key == '0) begin
          rep.status = kct_pkg::STAT_IGNORED;
        end else if (r.amount <= 0) begin
          rep.status = kct_pkg::STAT_IGNORED;
          if (hit >= 0) rep.count = tbl_count[hit];
        end else if (hit < 0) begin
          rep.status = kct_pkg::STAT_NOTFOUND;
        end else begin
          total = longint'(tbl_count[hit]) - longint'(r.amount);
          if (total <= 0) tbl_used[hit] = 1'b0;
          else begin
            tbl_count[hit] = total[30:0];
            rep.count      = total[30:0];
          end
          rep.changed = 1'b1;
        end
      end
    endcase
    return rep;
  endfunction

  // Random key: mostly from a small pool so that keys meet again.
  function automatic logic [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 13) return $urandom;
    return key_pool[$urandom_range(0, KEY_POOL - 1)];
  endfunction

  // Random amount: mostly small positive, some huge, some nonpositive.
  function automatic logic [31:0] pick_amount(logic for_remove);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 8) return 32'h8000_0000 | $urandom;
    if (roll < 16) return $urandom;
    if (roll < 24) return 32'h4000_0000 + $urandom_range(0, 32'h3FFF_FFFF);
    return $urandom_range(1, for_remove ? 1500 : 1000);
  endfunction

  // Random query threshold: near typical counts or anywhere.
  function automatic logic [31:0] pick_min();
    if ($urandom_range(0, 99) < 60) return 32'($urandom_range(0, 4000)) - 32'd300;
    return $urandom;
  endfunction

  task automatic push_req(input logic [1:0] req, input logic [31:0] key,
                          input logic [31:0] amt, input logic flag, input logic [31:0] minc);
    request_t r;
    r.req     = req;
    r.key     = key;
    r.amount  = amt;
    r.flag    = flag;
    r.min_cnt = minc;
    r.gap     = (src_max_gap == 0) ? 0 : $urandom_range(0, src_max_gap);
    request_fifo.push_back(r);
  endtask

  task automatic push_random();
    int         roll;
    logic [1:0] req;
    roll = $urandom_range(0, 99);
    if (roll < 45) req = kct_pkg::REQ_ADD;
    else if (roll < 70) req = kct_pkg::REQ_REMOVE;
    else if (roll < 98) req = kct_pkg::REQ_QUERY;
    else req = kct_pkg::REQ_CLEAR;
    push_req(req, pick_key(), pick_amount(req == kct_pkg::REQ_REMOVE), 1'($urandom),
             pick_min());
  endtask

  // Waits until every word has been sent and every result has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (request_fifo.size() != 0 || src_loaded || src_busy || count_replies_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    key_limit = value;
  endtask

  // Request driver: presents one word after its gap and holds it until taken.
  always @(negedge clk) begin : req_driver
    if (!rst) begin
      if (req_taken) begin
        req_taken = 1'b0;
        src_busy  = 1'b0;
      end
      if (!src_busy && !src_loaded && request_fifo.size() != 0) begin
        bus_req    = request_fifo.pop_front();
        src_wait   = bus_req.gap;
        src_loaded = 1'b1;
      end
      if (!src_busy && src_loaded) begin
        if (src_wait == 0) begin
          s_axis_tdata <= {7'd0, bus_req.min_cnt, bus_req.flag, bus_req.amount, bus_req.key};
          s_axis_tuser <= bus_req.req;
          src_busy   = 1'b1;
          src_loaded = 1'b0;
        end else begin
          src_wait--;
        end
      end
      s_axis_tvalid <= src_busy;
    end
  end

  // Request acceptance: predict the result of each word taken.
  always @(posedge clk) begin : req_accept
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      req_taken = 1'b1;
      count_replies_due.push_back(table_apply(bus_req));
    end
  end

  // Result sink: stalls a random number of cycles after each word.
  always @(negedge clk) begin : rsp_sink
    if (rsp_taken) begin
      rsp_taken = 1'b0;
      snk_wait  = (snk_max_stall == 0) ? 0 : $urandom_range(0, snk_max_stall);
    end else if (snk_wait > 0) begin
      snk_wait--;
    end
    m_axis_tready <= (snk_wait == 0);
  end

  // Result monitor: compares each word with the oldest prediction.
  always @(posedge clk) begin : rsp_monitor
    reply_t got;
    reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      rsp_taken   = 1'b1;
      got.status  = m_axis_tuser;
      got.count   = m_axis_tdata[30:0];
      got.enough  = m_axis_tdata[31];
      got.changed = m_axis_tdata[32];
      if (count_replies_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result word with no request outstanding: status=%0d count=%0d",
                   $realtime, got.status, got.count);
      end else begin
        want = count_replies_due.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"%0t: mismatch: expected status=%0d count=%0d enough=%0b changed=%0b,",
                      " got status=%0d count=%0d enough=%0b changed=%0b"}, $realtime,
                     want.status, want.count, want.enough, want.changed,
                     got.status, got.count, got.enough, got.changed);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus: directed phases, then random segments under changing limits.
  initial begin : stimulus
    logic [4:0] seg_limit;
    key_pool[0] = 32'h0000_0001;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    for (int i = 3; i < KEY_POOL; i++) key_pool[i] = $urandom | 32'h1;
    for (int i = 0; i < DEPTH; i++) tbl_used[i] = 1'b0;
    key_limit = kct_pkg::MAX_ENTRIES_RESET;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Field extremes and the special cases at the reset limit.
    push_req(kct_pkg::REQ_ADD,    32'h0000_0001, 32'd5,         1'b1, 32'd0);
    push_req(kct_pkg::REQ_ADD,    32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'd0);
    push_req(kct_pkg::REQ_ADD,    32'hFFFF_FFFF, 32'd1,         1'b1, 32'd0);
    push_req(kct_pkg::REQ_ADD,    32'h0000_0000, 32'd5,         1'b1, 32'd0);
    push_req(kct_pkg::REQ_ADD,    32'h0000_0001, 32'd0,         1'b0, 32'd0);
    push_req(kct_pkg::REQ_ADD,    32'h0000_0001, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF);
    push_req(kct_pkg::REQ_REMOVE, 32'h0000_0001, 32'd0,         1'b0, 32'd0);
    push_req(kct_pkg::REQ_REMOVE, 32'h0000_0002, 32'hFFFF_FFFF, 1'b0, 32'd0);
    push_req(kct_pkg::REQ_REMOVE, 32'h0000_0000, 32'd3,         1'b0, 32'd0);
    push_req(kct_pkg::REQ_REMOVE, 32'h0000_0003, 32'd1,         1'b0, 32'd0);
    push_req(kct_pkg::REQ_QUERY,  32'h0000_0000, 32'd0,         1'b0, 32'd0);
    push_req(kct_pkg::REQ_QUERY,  32'h0000_0000, 32'd0,         1'b0, 32'd1);
    push_req(kct_pkg::REQ_QUERY,  32'h0000_0003, 32'd0,         1'b0, 32'h8000_0000);
    push_req(kct_pkg::REQ_QUERY,  32'hFFFF_FFFF, 32'd0,         1'b0, 32'h7FFF_FFFF);
    push_req(kct_pkg::REQ_QUERY,  32'h0000_0001, 32'd0,         1'b0, 32'd6);
    push_req(kct_pkg::REQ_REMOVE, 32'h0000_0001, 32'd2,         1'b0, 32'd0);
    push_req(kct_pkg::REQ_REMOVE, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 32'd0);
    push_req(kct_pkg::REQ_CLEAR,  32'h0000_0000, 32'd0,         1'b0, 32'd0);
    push_req(kct_pkg::REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    wait_idle();

    // A small limit: the third new key finds the table full.
    write_limit(5'd2);
    push_req(kct_pkg::REQ_ADD, 32'h0000_0011, 32'd1, 1'b0, 32'd0);
    push_req(kct_pkg::REQ_ADD, 32'h0000_0022, 32'd2, 1'b1, 32'd0);
    push_req(kct_pkg::REQ_ADD, 32'h0000_0033, 32'd3, 1'b0, 32'd0);
    push_req(kct_pkg::REQ_ADD, 32'h0000_0011, 32'd4, 1'b1, 32'd0);
    wait_idle();

    // A limit above the depth: the seventeenth new key is still refused.
    write_limit(5'd31);
    src_max_gap   = 0;
    snk_max_stall = 0;
    push_req(kct_pkg::REQ_CLEAR, 32'h0, 32'd0, 1'b0, 32'd0);
    for (int i = 0; i <= DEPTH; i++)
      push_req(kct_pkg::REQ_ADD, 32'h0000_0100 + 32'(i), 32'(i + 1), 1'(i), 32'd0);
    wait_idle();

    // Random segments, each under its own limit and idling pattern.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       seg_limit = 5'd16;
        1:       seg_limit = 5'd0;
        2:       seg_limit = 5'd31;
        3:       seg_limit = 5'd1;
        4:       seg_limit = 5'd5;
        5:       seg_limit = 5'd16;
        default: seg_limit = 5'($urandom_range(0, 31));
      endcase
      write_limit(seg_limit);
      src_max_gap   = (seg % 3 == 1) ? 0 : MAX_GAP;
      snk_max_stall = (seg % 4 == 2) ? 0 : MAX_GAP;
      for (int n = 0; n < SEG_ITEMS; n++) push_random();
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && count_replies_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/kct_pkg.sv
rtl/core/kct_ram.sv
rtl/core/keyed_count_table.sv
sim/keyed_count_table_tb.sv
